// File: rtl/core/fcp_pkg.sv
// shared types and constants of the framed command parser
package fcp_pkg;

  // framing and command bytes
  localparam logic [7:0] ByteStart   = 8'h3C;  // '<'
  localparam logic [7:0] ByteEnd     = 8'h3E;  // '>'
  localparam logic [7:0] LetterMode  = 8'h4D;  // 'M'
  localparam logic [7:0] LetterPos   = 8'h50;  // 'P'
  localparam logic [7:0] LetterCalib = 8'h43;  // 'C'
  localparam logic [7:0] LetterError = 8'h45;  // 'E'

  // axis codes of a position frame
  localparam logic [7:0] AxisShoulder = 8'd100;
  localparam logic [7:0] AxisElbow    = 8'd101;
  localparam logic [7:0] AxisGripper  = 8'd102;

  // operating modes
  localparam logic [1:0] ModeManual = 2'd2;
  localparam logic [7:0] ModeMax    = 8'd3;

  // configuration register indexes
  localparam logic [1:0] CfgModeLen  = 2'd0;
  localparam logic [1:0] CfgPosLen   = 2'd1;
  localparam logic [1:0] CfgCalibLen = 2'd2;
  localparam logic [1:0] CfgErrorLen = 2'd3;

  typedef enum logic [1:0] {
    KindMode  = 2'd0,
    KindPos   = 2'd1,
    KindCalib = 2'd2,
    KindError = 2'd3
  } cmd_kind_e;

  // payload lengths per command kind
  typedef struct packed {
    logic [3:0] mode_len;
    logic [3:0] pos_len;
    logic [3:0] calib_len;
    logic [3:0] error_len;
  } len_cfg_t;

  // one classified word handed from the parser to the executor
  typedef struct packed {
    logic      accepted;
    logic      dropped;
    cmd_kind_e kind;
    logic [7:0] first_payload;
    logic [7:0] second_payload;
  } fcp_entry_t;

endpackage

// File: rtl/core/fcp_ifs.sv
// valid/ready channel interfaces of the framed command parser

interface fcp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface fcp_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] op_mode;
  logic [7:0] shoulder_target;
  logic [7:0] elbow_target;
  logic [7:0] gripper_target;
  logic       frame_accepted;
  logic       frame_dropped;

  modport source (
    output valid, output op_mode, output shoulder_target, output elbow_target,
    output gripper_target, output frame_accepted, output frame_dropped,
    input ready
  );
  modport sink (
    input valid, input op_mode, input shoulder_target, input elbow_target,
    input gripper_target, input frame_accepted, input frame_dropped,
    output ready
  );
endinterface

interface fcp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [3:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/fcp_front.sv
// frame parser: tracks framing and classifies every received byte
module fcp_front import fcp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] rx_byte_i,
  output logic       ready_o,
  input  len_cfg_t   len_cfg_i,
  input  logic       q_full_i,
  output logic       push_o,
  output fcp_entry_t entry_o
);

  localparam logic [1:0] PhWait    = 2'd0;
  localparam logic [1:0] PhCmd     = 2'd1;
  localparam logic [1:0] PhPayload = 2'd2;
  localparam logic [1:0] PhClose   = 2'd3;

  logic [1:0] phase_q, phase_d;
  cmd_kind_e  kind_q, kind_d;
  logic [3:0] count_q, count_d;
  logic [7:0] first_q, first_d;
  logic [7:0] second_q, second_d;
  logic [3:0] need;
  logic       accepted;
  logic       dropped;

  assign ready_o = !q_full_i;
  assign push_o  = valid_i && ready_o;

  always_comb begin
    case (kind_q)
      KindMode:  need = len_cfg_i.mode_len;
      KindPos:   need = len_cfg_i.pos_len;
      KindCalib: need = len_cfg_i.calib_len;
      default:   need = len_cfg_i.error_len;
    endcase
    if (need == 4'd0) begin
      need = 4'd1;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    kind_d   = kind_q;
    count_d  = count_q;
    first_d  = first_q;
    second_d = second_q;
    accepted = 1'b0;
    dropped  = 1'b0;
    unique case (phase_q)
      PhWait: begin
        if (rx_byte_i == ByteStart) begin
          phase_d = PhCmd;
        end
      end
      PhCmd: begin
        phase_d = PhPayload;
        count_d = 4'd0;
        // unknown letters keep the previous kind
        if (rx_byte_i == LetterMode) begin
          kind_d = KindMode;
        end else if (rx_byte_i == LetterPos) begin
          kind_d = KindPos;
        end else if (rx_byte_i == LetterCalib) begin
          kind_d = KindCalib;
        end else if (rx_byte_i == LetterError) begin
          kind_d = KindError;
        end
      end
      PhPayload: begin
        if (count_q != 4'd15) begin
          count_d = count_q + 4'd1;
        end
        if (count_d == 4'd1) begin
          first_d = rx_byte_i;
        end else if (count_d == 4'd2) begin
          second_d = rx_byte_i;
        end
        if (count_d >= need) begin
          phase_d = PhClose;
        end
      end
      PhClose: begin
        accepted = (rx_byte_i == ByteEnd);
        dropped  = !accepted;
        phase_d  = PhWait;
      end
    endcase
  end

  always_comb begin
    entry_o.accepted       = accepted;
    entry_o.dropped        = dropped;
    entry_o.kind           = kind_q;
    entry_o.first_payload  = first_q;
    entry_o.second_payload = second_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhWait;
      kind_q   <= KindMode;
      count_q  <= 4'd0;
      first_q  <= 8'd0;
      second_q <= 8'd0;
    end else if (push_o) begin
      phase_q  <= phase_d;
      kind_q   <= kind_d;
      count_q  <= count_d;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

endmodule

// File: rtl/core/fcp_fifo.sv
// short word queue between parser and executor
module fcp_fifo import fcp_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  fcp_entry_t push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output fcp_entry_t pop_data_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);

  fcp_entry_t          mem_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                do_push, do_pop;

  assign full_o     = (count_q == CntFull);
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/fcp_back.sv
// executor: applies closed frames and holds the result word
module fcp_back import fcp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  fcp_entry_t entry_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] op_mode_o,
  output logic [7:0] shoulder_o,
  output logic [7:0] elbow_o,
  output logic [7:0] gripper_o,
  output logic       accepted_o,
  output logic       dropped_o
);

  logic       valid_q;
  logic [1:0] mode_q, mode_d;
  logic [7:0] shoulder_q, shoulder_d;
  logic [7:0] elbow_q, elbow_d;
  logic [7:0] gripper_q, gripper_d;
  logic       accepted_q, dropped_q;

  assign pop_o = !q_empty_i && (!valid_q || out_ready_i);

  always_comb begin
    mode_d     = mode_q;
    shoulder_d = shoulder_q;
    elbow_d    = elbow_q;
    gripper_d  = gripper_q;
    if (entry_i.accepted) begin
      if (entry_i.kind == KindMode) begin
        if (entry_i.first_payload <= ModeMax) begin
          mode_d = entry_i.first_payload[1:0];
        end
      end else if (entry_i.kind == KindPos && mode_q == ModeManual) begin
        if (entry_i.first_payload == AxisShoulder) begin
          shoulder_d = entry_i.second_payload;
        end else if (entry_i.first_payload == AxisElbow) begin
          elbow_d = entry_i.second_payload;
        end else if (entry_i.first_payload == AxisGripper) begin
          gripper_d = entry_i.second_payload;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      mode_q     <= 2'd0;
      shoulder_q <= 8'd0;
      elbow_q    <= 8'd0;
      gripper_q  <= 8'd0;
      accepted_q <= 1'b0;
      dropped_q  <= 1'b0;
    end else if (pop_o) begin
      valid_q    <= 1'b1;
      mode_q     <= mode_d;
      shoulder_q <= shoulder_d;
      elbow_q    <= elbow_d;
      gripper_q  <= gripper_d;
      accepted_q <= entry_i.accepted;
      dropped_q  <= entry_i.dropped;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  assign out_valid_o = valid_q;
  assign op_mode_o   = mode_q;
  assign shoulder_o  = shoulder_q;
  assign elbow_o     = elbow_q;
  assign gripper_o   = gripper_q;
  assign accepted_o  = accepted_q;
  assign dropped_o   = dropped_q;

endmodule

// File: rtl/core/framed_command_parser.sv
// top level of the framed command parser
//
// usage:
//   byte_i   : one received serial byte per word ('<', letter, payload, close)
//   result_o : one word per accepted byte: mode, the three axis targets as
//              they stand after that byte, and accepted/dropped frame flags
//   cfg_i    : payload length registers, index 0 mode, 1 position,
//              2 calibration, 3 error; always ready, write only while idle
// path: a taken byte's word enters the queue, then the output register
// throughput: one byte per cycle while the queue is not full; every part
//   does one small update per byte
// reset: parser waits for '<', mode 0, targets zero, lengths 1/2/3/10,
//   queue and output register empty
// stall: while result_o is held the parser keeps taking bytes until the
//   queue (QueueDepth words) is full, then byte_i.ready drops
module framed_command_parser import fcp_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  fcp_byte_if.sink      byte_i,
  fcp_result_if.source  result_o,
  fcp_cfg_if.sink       cfg_i
);

  len_cfg_t   len_cfg_q;
  fcp_entry_t push_entry;
  fcp_entry_t pop_entry;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_empty;

  // config registers, every write taken at once
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_cfg_q.mode_len  <= 4'd1;
      len_cfg_q.pos_len   <= 4'd2;
      len_cfg_q.calib_len <= 4'd3;
      len_cfg_q.error_len <= 4'd10;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgModeLen:  len_cfg_q.mode_len  <= cfg_i.data;
        CfgPosLen:   len_cfg_q.pos_len   <= cfg_i.data;
        CfgCalibLen: len_cfg_q.calib_len <= cfg_i.data;
        CfgErrorLen: len_cfg_q.error_len <= cfg_i.data;
      endcase
    end
  end

  // front: framing and classification, one queue word per byte
  fcp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (byte_i.valid),
    .rx_byte_i (byte_i.rx_byte),
    .ready_o   (byte_i.ready),
    .len_cfg_i (len_cfg_q),
    .q_full_i  (q_full),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  // decouples parsing from the output handshake
  fcp_fifo #(
    .QueueDepth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .pop_data_o  (pop_entry)
  );

  // back: owns mode and targets, registers the result word
  fcp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .entry_i     (pop_entry),
    .pop_o       (pop),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .op_mode_o   (result_o.op_mode),
    .shoulder_o  (result_o.shoulder_target),
    .elbow_o     (result_o.elbow_target),
    .gripper_o   (result_o.gripper_target),
    .accepted_o  (result_o.frame_accepted),
    .dropped_o   (result_o.frame_dropped)
  );

endmodule
